@@ hw/rtl/tlvfx_pkg.sv @@
// tlvfx_pkg: shared codes and result layout of the tlv field extractor
package tlvfx_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_TYPE       = 2'd0,
        REG_TARGET_OCCURRENCE = 2'd1,
        REG_TARGET_CODING     = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        CODE_PRESENCE = 3'd0,
        CODE_BOOL     = 3'd1,
        CODE_INT      = 3'd2,
        CODE_FLOAT    = 3'd3,
        CODE_BINARY   = 3'd4
    } coding_t;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_BAD_SIZE  = 2'd3
    } status_t;

    // first member sits in the highest bits
    typedef struct packed {
        logic [7:0]  message_number;
        logic [7:0]  message_kind;
        logic [7:0]  destination_address;
        logic [7:0]  source_address;
        logic [7:0]  value_length;
        logic [7:0]  value_offset;
        logic [31:0] value_word;
        status_t     status;
    } result_t;

    localparam int RESULT_W   = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ hw/rtl/tlv_field_extractor.sv @@
// tlv_field_extractor: searches each message for one type-length-value element and decodes it
//
// Takes one message byte per clock cycle with no gaps of its own: every byte updates the parser
// state in the cycle it is accepted, so the rate is one byte per cycle, and the single result of
// a message appears in the output register on the cycle after its last byte. The input is held
// off only while a finished result waits on a stalled output. Registers may be written while no
// message is in progress; target_occurrence is picked up on the first byte of a message.
module tlv_field_extractor #(
    parameter int HEADER_BYTES  = 4,
    parameter int PAYLOAD_BYTES = 28
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,   // data_byte
    input  logic                                   s_tlast,   // last_byte
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // status, value_word, value_offset, value_length, source_address,
    // destination_address, message_kind, message_number, zero fill
    output logic [tlvfx_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tlvfx_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tlvfx_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tlvfx_pkg::*;

    localparam logic [8:0] MSG_LIMIT  = 9'(HEADER_BYTES + PAYLOAD_BYTES);
    localparam logic [8:0] HDR_LEN    = 9'(HEADER_BYTES);
    localparam logic [7:0] POS_SAT    = 8'd255;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LENGTH = 3'd2,
        PH_SKIP   = 3'd3,
        PH_VALUE  = 3'd4
    } phase_t;

    // configuration
    logic [15:0] target_type_reg;
    logic [7:0]  target_occ_reg;
    logic [2:0]  target_coding_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_pos_reg, byte_pos_next;
    logic [15:0] type_acc_reg, type_acc_next;
    logic        type_over_reg, type_over_next;
    logic [15:0] alt_type_reg, alt_type_next;
    logic        alt_over_reg, alt_over_next;
    logic [7:0]  skip_reg, skip_next;
    logic [7:0]  occ_left_reg, occ_left_next;
    logic [7:0]  elem_start_reg, elem_start_next;
    logic [7:0]  elem_len_reg, elem_len_next;
    logic [31:0] value_acc_reg, value_acc_next;
    logic [7:0]  value_left_reg, value_left_next;
    logic        match_reg, match_next;
    logic [7:0]  header_reg [4];
    logic [7:0]  header_next [4];

    // output register
    logic        out_valid_reg;
    result_t     result_reg, result_next;

    // working signals
    logic        accept;
    logic [7:0]  cur;
    logic [8:0]  cur_inc;
    logic [7:0]  since_start;
    logic        do_take;
    logic        do_begin;
    logic [15:0] tl_type;
    logic        tl_over;
    logic [15:0] type_step;
    logic [7:0]  skip_dec;
    logic [7:0]  value_idx;
    logic [8:0]  avail;
    logic        len_ok;
    logic        has_word;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_DATA_W'(result_reg);
    assign cfg_ready = 1'b1;

    assign cur         = byte_pos_reg;
    assign cur_inc     = {1'b0, cur} + 9'd1;
    assign since_start = cur - elem_start_reg;
    assign type_step   = type_acc_reg | {9'd0, s_tdata[6:0]};
    assign skip_dec    = (skip_reg != 8'd0) ? skip_reg - 8'd1 : 8'd0;
    assign value_idx   = elem_len_reg - value_left_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        type_acc_next   = type_acc_reg;
        type_over_next  = type_over_reg;
        alt_type_next   = alt_type_reg;
        alt_over_next   = alt_over_reg;
        skip_next       = skip_reg;
        occ_left_next   = (cur == 8'd0) ? target_occ_reg : occ_left_reg;
        elem_start_next = elem_start_reg;
        elem_len_next   = elem_len_reg;
        value_acc_next  = value_acc_reg;
        value_left_next = value_left_reg;
        match_next      = match_reg;
        for (int i = 0; i < 4; i++)
        begin
            header_next[i] = header_reg[i];
        end
        byte_pos_next = (cur != POS_SAT) ? cur + 8'd1 : cur;
        do_take  = 1'b0;
        do_begin = 1'b0;
        tl_type  = type_acc_reg;
        tl_over  = type_over_reg;

        if (cur < 8'd4)
        begin
            header_next[cur[1:0]] = s_tdata;
        end

        if ({1'b0, cur} < MSG_LIMIT)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (cur_inc >= HDR_LEN)
                    begin
                        do_begin = 1'b1;
                    end
                end
                PH_TYPE:
                begin
                    if (s_tlast)
                    begin
                        if (since_start >= 8'd2)
                        begin
                            do_take = 1'b1;
                            tl_type = alt_type_reg;
                            tl_over = alt_over_reg;
                        end
                    end
                    else if (s_tdata[7])
                    begin
                        alt_type_next = type_acc_reg | {8'd0, s_tdata};
                        alt_over_next = type_over_reg;
                        if (type_step[15:9] != 7'd0)
                        begin
                            type_over_next = 1'b1;
                        end
                        type_acc_next = {type_step[8:0], 7'd0};
                    end
                    else
                    begin
                        type_acc_next = type_acc_reg | {8'd0, s_tdata};
                        phase_next    = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    if (!s_tlast || since_start >= 8'd2)
                    begin
                        do_take = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 8'd0 && !s_tlast)
                    begin
                        do_begin = 1'b1;
                    end
                end
                PH_VALUE:
                begin
                    if (value_left_reg != 8'd0)
                    begin
                        priority case (target_coding_reg)
                            CODE_BOOL:
                            begin
                                if (value_idx == 8'd0)
                                begin
                                    value_acc_next = {31'd0, s_tdata != 8'd0};
                                end
                            end
                            CODE_INT:
                            begin
                                if (value_idx == 8'd0)
                                begin
                                    value_acc_next = {{24{s_tdata[7]}}, s_tdata};
                                end
                                else
                                begin
                                    value_acc_next = {value_acc_reg[23:0], s_tdata};
                                end
                            end
                            CODE_FLOAT:
                            begin
                                if (value_idx < 8'd4)
                                begin
                                    value_acc_next = value_acc_reg
                                        | ({24'd0, s_tdata} << {value_idx[1:0], 3'd0});
                                end
                            end
                            default:
                            begin
                                value_acc_next = value_acc_reg;
                            end
                        endcase
                        value_left_next = value_left_reg - 8'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (do_take)
        begin
            elem_len_next = s_tdata;
            if (!tl_over && tl_type == target_type_reg && occ_left_next == 8'd0)
            begin
                match_next      = 1'b1;
                phase_next      = PH_VALUE;
                elem_start_next = cur_inc[7:0];
                value_left_next = s_tdata;
                value_acc_next  = 32'd0;
            end
            else
            begin
                if (!tl_over && tl_type == target_type_reg)
                begin
                    occ_left_next = occ_left_next - 8'd1;
                end
                if (s_tdata == 8'd0)
                begin
                    do_begin = 1'b1;
                end
                else
                begin
                    skip_next  = s_tdata;
                    phase_next = PH_SKIP;
                end
            end
        end

        if (do_begin)
        begin
            phase_next      = PH_TYPE;
            elem_start_next = cur_inc[7:0];
            type_acc_next   = 16'd0;
            type_over_next  = 1'b0;
            alt_type_next   = 16'd0;
            alt_over_next   = 1'b0;
        end
    end

    // result of a message that ends on this byte
    always_comb
    begin
        avail    = cur_inc - {1'b0, elem_start_next};
        len_ok   = 1'b1;
        has_word = 1'b0;
        priority case (target_coding_reg)
            CODE_BOOL:
            begin
                len_ok   = elem_len_next >= 8'd1 && avail >= 9'd1;
                has_word = 1'b1;
            end
            CODE_INT:
            begin
                len_ok   = elem_len_next >= 8'd1 && avail >= {1'b0, elem_len_next};
                has_word = 1'b1;
            end
            CODE_FLOAT:
            begin
                len_ok   = elem_len_next >= 8'd4 && avail >= 9'd4;
                has_word = 1'b1;
            end
            CODE_BINARY:
            begin
                len_ok = avail >= {1'b0, elem_len_next};
            end
            default:
            begin
                len_ok = 1'b1;
            end
        endcase

        result_next.source_address      = header_next[0];
        result_next.destination_address = header_next[1];
        result_next.message_kind        = header_next[2];
        result_next.message_number      = header_next[3];
        result_next.value_word          = 32'd0;
        result_next.value_offset        = 8'd0;
        result_next.value_length        = 8'd0;
        if ({1'b0, cur} >= MSG_LIMIT || cur_inc < HDR_LEN)
        begin
            result_next.status = ST_BAD_SIZE;
        end
        else if (match_next)
        begin
            result_next.status       = len_ok ? ST_FOUND : ST_BAD_LEN;
            result_next.value_offset = elem_start_next;
            result_next.value_length = elem_len_next;
            if (len_ok && has_word)
            begin
                result_next.value_word = value_acc_next;
            end
        end
        else
        begin
            result_next.status = ST_NOT_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_type_reg   <= '0;
            target_occ_reg    <= '0;
            target_coding_reg <= '0;
            phase_reg         <= PH_HEADER;
            byte_pos_reg      <= '0;
            type_acc_reg      <= '0;
            type_over_reg     <= 1'b0;
            alt_type_reg      <= '0;
            alt_over_reg      <= 1'b0;
            skip_reg          <= '0;
            occ_left_reg      <= '0;
            elem_start_reg    <= '0;
            elem_len_reg      <= '0;
            value_acc_reg     <= '0;
            value_left_reg    <= '0;
            match_reg         <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                header_reg[i] <= '0;
            end
            out_valid_reg     <= 1'b0;
            result_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TARGET_TYPE)
                begin
                    target_type_reg <= cfg_data;
                end
                if (cfg_index == REG_TARGET_OCCURRENCE)
                begin
                    target_occ_reg <= cfg_data[7:0];
                end
                if (cfg_index == REG_TARGET_CODING)
                begin
                    target_coding_reg <= cfg_data[2:0];
                end
            end

            if (accept && s_tlast)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                occ_left_reg <= occ_left_next;
                if (s_tlast)
                begin
                    result_reg     <= result_next;
                    phase_reg      <= PH_HEADER;
                    byte_pos_reg   <= '0;
                    type_acc_reg   <= '0;
                    type_over_reg  <= 1'b0;
                    alt_type_reg   <= '0;
                    alt_over_reg   <= 1'b0;
                    skip_reg       <= '0;
                    elem_start_reg <= '0;
                    elem_len_reg   <= '0;
                    value_acc_reg  <= '0;
                    value_left_reg <= '0;
                    match_reg      <= 1'b0;
                    for (int i = 0; i < 4; i++)
                    begin
                        header_reg[i] <= '0;
                    end
                end
                else
                begin
                    phase_reg      <= phase_next;
                    byte_pos_reg   <= byte_pos_next;
                    type_acc_reg   <= type_acc_next;
                    type_over_reg  <= type_over_next;
                    alt_type_reg   <= alt_type_next;
                    alt_over_reg   <= alt_over_next;
                    skip_reg       <= skip_next;
                    elem_start_reg <= elem_start_next;
                    elem_len_reg   <= elem_len_next;
                    value_acc_reg  <= value_acc_next;
                    value_left_reg <= value_left_next;
                    match_reg      <= match_next;
                    for (int i = 0; i < 4; i++)
                    begin
                        header_reg[i] <= header_next[i];
                    end
                end
            end
        end
    end

    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> m_tvalid)
        else $error("no result after last word");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> byte_pos_reg == 8'd0 && phase_reg == PH_HEADER && !match_reg)
        else $error("parser not restarted after last word");

    a_match_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        match_reg |-> phase_reg == PH_VALUE)
        else $error("match held outside value phase");

    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result_reg.status == ST_NOT_FOUND || result_reg.status == ST_BAD_SIZE)
        |-> result_reg.value_offset == 8'd0 && result_reg.value_length == 8'd0
            && result_reg.value_word == 32'd0)
        else $error("value fields set without a match");

endmodule

@@ bench/tlv_field_extractor_test.sv @@
// tlv_field_extractor_test: self-checking bench for the tlv field extractor, directed messages then random streams
module tlv_field_extractor_test;
    import tlvfx_pkg::*;

    localparam int HDR_LEN    = 4;
    localparam int SIZE_LIMIT = 32;
    localparam int PHASES     = 12;
    localparam int LIMIT      = 300000;

    typedef enum logic [2:0] {W_HEADER, W_TYPE, W_LENGTH, W_SKIP, W_VALUE} walk_t;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} pace_t;

    typedef struct packed {
        logic [15:0]       ttype;
        logic [7:0]        tocc;
        logic [2:0]        tcode;
        logic [9:0]        total;
        logic [7:0]        fill;
        logic [0:11][7:0]  body;
        logic              typed;
        status_t           st;
        logic [31:0]       word;
    } probe_t;

    localparam probe_t PROBES [23] = '{
        '{16'h0000, 8'd0, CODE_PRESENCE, 10'd7, 8'h00,
          96'h00_00_00_00_00_00_00_00_00_00_00_00, 1'b1, ST_FOUND, 32'h0},
        '{16'h007F, 8'd0, CODE_BOOL, 10'd8, 8'h00,
          96'hFF_FF_FF_FF_7F_01_80_00_00_00_00_00, 1'b1, ST_FOUND, 32'h1},
        '{16'hFFFF, 8'd0, CODE_INT, 10'd10, 8'h00,
          96'h12_34_56_78_83_FF_7F_02_80_01_00_00, 1'b1, ST_FOUND, 32'hFFFF_8001},
        '{16'h0001, 8'd0, CODE_INT, 10'd12, 8'h00,
          96'h12_34_56_78_01_06_01_02_03_04_05_06, 1'b1, ST_FOUND, 32'h0304_0506},
        '{16'h0002, 8'd0, CODE_INT, 10'd7, 8'h00,
          96'h12_34_56_78_02_00_00_00_00_00_00_00, 1'b1, ST_BAD_LEN, 32'h0},
        '{16'h0002, 8'd0, CODE_BOOL, 10'd7, 8'h00,
          96'h12_34_56_78_02_00_00_00_00_00_00_00, 1'b1, ST_BAD_LEN, 32'h0},
        '{16'h0003, 8'd0, CODE_FLOAT, 10'd9, 8'h00,
          96'h12_34_56_78_03_03_AA_BB_CC_00_00_00, 1'b1, ST_BAD_LEN, 32'h0},
        '{16'h0003, 8'd0, CODE_FLOAT, 10'd10, 8'h00,
          96'h12_34_56_78_03_04_00_00_80_3F_00_00, 1'b1, ST_FOUND, 32'h3F80_0000},
        '{16'h0004, 8'd0, CODE_BINARY, 10'd8, 8'h00,
          96'h12_34_56_78_04_09_01_02_00_00_00_00, 1'b1, ST_BAD_LEN, 32'h0},
        '{16'h0004, 8'd0, CODE_INT, 10'd8, 8'h00,
          96'h12_34_56_78_04_03_01_02_00_00_00_00, 1'b1, ST_BAD_LEN, 32'h0},
        '{16'h1234, 8'd0, CODE_BINARY, 10'd11, 8'h00,
          96'h12_34_56_78_A4_34_03_AA_BB_CC_00_00, 1'b1, ST_FOUND, 32'h0},
        '{16'h0000, 8'd0, CODE_PRESENCE, 10'd10, 8'h00,
          96'h12_34_56_78_84_80_80_00_00_00_00_00, 1'b1, ST_NOT_FOUND, 32'h0},
        '{16'h0082, 8'd0, CODE_PRESENCE, 10'd9, 8'h00,
          96'h12_34_56_78_05_00_81_82_05_00_00_00, 1'b1, ST_FOUND, 32'h0},
        '{16'h0007, 8'd1, CODE_INT, 10'd11, 8'h00,
          96'h12_34_56_78_07_01_11_07_01_22_00_00, 1'b1, ST_FOUND, 32'h22},
        '{16'h0007, 8'd255, CODE_INT, 10'd11, 8'h00,
          96'h12_34_56_78_07_01_11_07_01_22_00_00, 1'b1, ST_NOT_FOUND, 32'h0},
        '{16'h0009, 8'd0, 3'd7, 10'd9, 8'h00,
          96'h12_34_56_78_09_02_AB_CD_00_00_00_00, 1'b1, ST_FOUND, 32'h0},
        '{16'h0000, 8'd0, CODE_PRESENCE, 10'd1, 8'h00,
          96'hAB_00_00_00_00_00_00_00_00_00_00_00, 1'b1, ST_BAD_SIZE, 32'h0},
        '{16'h0000, 8'd0, CODE_PRESENCE, 10'd3, 8'h00,
          96'h01_02_03_00_00_00_00_00_00_00_00_00, 1'b1, ST_BAD_SIZE, 32'h0},
        '{16'h0000, 8'd0, CODE_PRESENCE, 10'd4, 8'h00,
          96'h01_02_03_04_00_00_00_00_00_00_00_00, 1'b1, ST_NOT_FOUND, 32'h0},
        '{16'h0000, 8'd0, CODE_PRESENCE, 10'd32, 8'h00,
          96'h00_00_00_00_00_00_00_00_00_00_00_00, 1'b1, ST_FOUND, 32'h0},
        '{16'h0000, 8'd0, CODE_PRESENCE, 10'd33, 8'h00,
          96'h00_00_00_00_00_00_00_00_00_00_00_00, 1'b1, ST_BAD_SIZE, 32'h0},
        '{16'hFFFF, 8'd255, CODE_BINARY, 10'd300, 8'hFF,
          96'hFF_FF_FF_FF_FF_FF_FF_FF_FF_FF_FF_FF, 1'b1, ST_BAD_SIZE, 32'h0},
        '{16'h0005, 8'd0, CODE_BOOL, 10'd9, 8'h00,
          96'hC3_5A_A5_3C_05_02_00_01_00_00_00_00, 1'b0, ST_FOUND, 32'h0}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [7:0]              s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    tlv_field_extractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the search settings and parser state
    logic [15:0]  want_type;
    logic [7:0]   want_occ;
    logic [2:0]   want_code;
    int unsigned  pos;
    walk_t        walk;
    int unsigned  tacc;
    int unsigned  skip_left;
    int unsigned  occ_left;
    int unsigned  el_start;
    int unsigned  el_len;
    int unsigned  vacc;
    int unsigned  vleft;
    bit           hit;
    bit           tovf;
    int unsigned  alt_t;
    bit           alt_ovf;
    logic [7:0]   hdr [4];

    result_t      due_results [$];
    bit           typed_on;
    status_t      typed_status;
    logic [31:0]  typed_word;

    logic [7:0]   frame [$];
    pace_t        idle_mode;
    int           cycles;
    int           errors;
    int           results_seen;
    int           bytes_sent;
    int           frames_sent;
    int           writes_done;

    function automatic void clear_message();
        pos = 0;
        walk = W_HEADER;
        tacc = 0;
        skip_left = 0;
        el_start = 0;
        el_len = 0;
        vacc = 0;
        vleft = 0;
        hit = 1'b0;
        tovf = 1'b0;
        alt_t = 0;
        alt_ovf = 1'b0;
        foreach (hdr[i]) hdr[i] = 8'h00;
    endfunction

    function automatic void open_element(int unsigned p);
        walk = W_TYPE;
        el_start = p & 'hFF;
        tacc = 0;
        tovf = 1'b0;
        alt_t = 0;
        alt_ovf = 1'b0;
    endfunction

    function automatic void got_length(int unsigned ty, bit ovf, int unsigned len,
                                       int unsigned nxt);
        el_len = len;
        if (!ovf && ty == want_type) begin
            if (occ_left == 0) begin
                hit = 1'b1;
                walk = W_VALUE;
                el_start = nxt & 'hFF;
                vleft = len;
                vacc = 0;
                return;
            end
            occ_left--;
        end
        if (len == 0)
        begin
            open_element(nxt);
        end
        else
        begin
            skip_left = len;
            walk = W_SKIP;
        end
    endfunction

    // one accepted byte; the last byte of a message yields its extraction result
    function automatic void extract_step(logic [7:0] b, bit last);
        int unsigned cur;
        int unsigned t;
        int unsigned idx;
        int unsigned avail;
        bit ok;
        result_t e;
        cur = pos;
        if (cur == 0)
            occ_left = want_occ;
        if (cur < 4)
            hdr[cur] = b;
        if (cur < SIZE_LIMIT) begin
            case (walk)
                W_HEADER:
                    if (cur + 1 >= HDR_LEN)
                        open_element(cur + 1);
                W_TYPE:
                    if (last)
                    begin
                        // type cut short by the end of the message
                        if (cur - el_start >= 2)
                            got_length(alt_t, alt_ovf, b, cur + 1);
                    end
                    else if (b[7])
                    begin
                        alt_t = tacc | b;
                        alt_ovf = tovf;
                        t = tacc | (b & 8'h7F);
                        if (t > 'h1FF)
                            tovf = 1'b1;
                        tacc = (t << 7) & 'hFFFF;
                    end
                    else
                    begin
                        tacc = (tacc | b) & 'hFFFF;
                        walk = W_LENGTH;
                    end
                W_LENGTH:
                    if (!last || cur - el_start >= 2)
                        got_length(tacc, tovf, b, cur + 1);
                    else
                        walk = W_SKIP;
                W_SKIP:
                begin
                    if (skip_left > 0)
                        skip_left--;
                    if (skip_left == 0 && !last)
                        open_element(cur + 1);
                end
                default:
                    if (vleft != 0) begin
                        idx = el_len - vleft;
                        if (want_code == CODE_BOOL)
                        begin
                            if (idx == 0)
                                vacc = (b != 0) ? 1 : 0;
                        end
                        else if (want_code == CODE_INT)
                        begin
                            if (idx == 0)
                                vacc = b | (b[7] ? 32'hFFFF_FF00 : 32'h0);
                            else
                                vacc = (vacc << 8) | b;
                        end
                        else if (want_code == CODE_FLOAT)
                        begin
                            if (idx < 4)
                                vacc = vacc | (32'(b) << (8 * idx));
                        end
                        vleft--;
                    end
            endcase
        end
        if (pos < 255)
            pos++;
        if (last) begin
            e = '0;
            if (cur >= SIZE_LIMIT || cur + 1 < HDR_LEN)
            begin
                e.status = ST_BAD_SIZE;
            end
            else if (hit)
            begin
                avail = cur + 1 - el_start;
                if (want_code == CODE_BOOL)
                    ok = el_len >= 1 && avail >= 1;
                else if (want_code == CODE_INT)
                    ok = el_len >= 1 && avail >= el_len;
                else if (want_code == CODE_FLOAT)
                    ok = el_len >= 4 && avail >= 4;
                else if (want_code == CODE_BINARY)
                    ok = avail >= el_len;
                else
                    ok = 1'b1;
                e.status = ok ? ST_FOUND : ST_BAD_LEN;
                e.value_offset = el_start[7:0];
                e.value_length = el_len[7:0];
                if (ok && (want_code == CODE_BOOL || want_code == CODE_INT ||
                           want_code == CODE_FLOAT))
                    e.value_word = vacc;
            end
            else
            begin
                e.status = ST_NOT_FOUND;
            end
            e.source_address = hdr[0];
            e.destination_address = hdr[1];
            e.message_kind = hdr[2];
            e.message_number = hdr[3];
            if (typed_on) begin
                e.status = typed_status;
                e.value_word = typed_word;
                typed_on = 1'b0;
            end
            due_results.push_back(e);
            clear_message();
        end
    endfunction

    function automatic bit takes_break(bit on_output);
        int unsigned pct;
        if (idle_mode == IDLE_BOTH)
            pct = 30;
        else if (idle_mode == (on_output ? IDLE_RECEIVER : IDLE_SENDER))
            pct = 46;
        else
            pct = 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
        end
    endfunction

    task automatic set_target(logic [15:0] ty, logic [7:0] occ, logic [2:0] code);
        reg_index_t idx_list [3];
        logic [15:0] val_list [3];
        idx_list = '{REG_TARGET_TYPE, REG_TARGET_OCCURRENCE, REG_TARGET_CODING};
        val_list = '{ty, {8'h00, occ}, {13'h0, code}};
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data <= val_list[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx_list[k])
                REG_TARGET_TYPE:       want_type = val_list[k];
                REG_TARGET_OCCURRENCE: want_occ = val_list[k][7:0];
                default:               want_code = val_list[k][2:0];
            endcase
            writes_done++;
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic push_byte(logic [7:0] b, bit last);
        while (takes_break(1'b0)) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        extract_step(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            push_byte(frame[i], i == frame.size() - 1);
        frames_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (due_results.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= !takes_break(1'b1);

    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            results_seen++;
            if (due_results.size() == 0)
            begin
                $error("result word with none pending: %0h", got);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("value_word", want.value_word, got.value_word);
                check_field("value_offset", 32'(want.value_offset), 32'(got.value_offset));
                check_field("value_length", 32'(want.value_length), 32'(got.value_length));
                check_field("source_address", 32'(want.source_address),
                            32'(got.source_address));
                check_field("destination_address", 32'(want.destination_address),
                            32'(got.destination_address));
                check_field("message_kind", 32'(want.message_kind), 32'(got.message_kind));
                check_field("message_number", 32'(want.message_number),
                            32'(got.message_number));
            end
        end
    end

    initial begin
        probe_t       row;
        logic [7:0]   grp [$];
        logic [15:0]  goal_type;
        logic [7:0]   goal_occ;
        logic [2:0]   goal_code;
        int unsigned  ety;
        int unsigned  v;
        int unsigned  len;
        int unsigned  plen;
        int unsigned  n;
        int unsigned  r;
        int unsigned  k;
        int           budget;
        bit           huge;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_TARGET_TYPE;
        cfg_data = '0;
        idle_mode = IDLE_NONE;
        cycles = 0;
        errors = 0;
        results_seen = 0;
        bytes_sent = 0;
        frames_sent = 0;
        writes_done = 0;
        typed_on = 1'b0;
        want_type = '0;
        want_occ = '0;
        want_code = '0;
        occ_left = 0;
        clear_message();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed messages
        for (int i = 0; i < $size(PROBES); i++) begin
            row = PROBES[i];
            wait_drained();
            idle_mode = pace_t'(i % 4);
            set_target(row.ttype, row.tocc, row.tcode);
            frame.delete();
            for (int j = 0; j < row.total; j++)
                frame.push_back(j < 12 ? row.body[j] : row.fill);
            typed_on = row.typed;
            typed_status = row.st;
            typed_word = row.word;
            send_frame();
        end

        // random streams, one register setting per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            idle_mode = pace_t'(ph % 4);
            r = $urandom_range(0, 9);
            goal_type = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                        (r < 6) ? 16'($urandom_range(0, 127)) :
                        (r < 8) ? 16'($urandom_range(128, 16383)) : 16'($urandom);
            r = $urandom_range(0, 9);
            goal_occ = (r == 0) ? 8'd255 : (r == 1) ? 8'($urandom) : 8'($urandom_range(0, 2));
            goal_code = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 4)) :
                        3'($urandom_range(5, 7));
            set_target(goal_type, goal_occ, goal_code);
            budget = 0;
            while (budget < 60) begin
                frame.delete();
                r = $urandom_range(0, 99);
                if (r < 16)
                begin
                    // noise, short messages among it
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
                    repeat (n) frame.push_back(8'($urandom));
                end
                else if (r < 98)
                begin
                    repeat (HDR_LEN) frame.push_back(8'($urandom));
                    plen = (r < 86) ? $urandom_range(0, 28) : $urandom_range(29, 44);
                    while (frame.size() < HDR_LEN + plen) begin
                        k = $urandom_range(0, 9);
                        huge = (k == 5);
                        if (k < 5)
                            ety = goal_type;
                        else if (k < 8)
                            ety = goal_type ^ (1 << $urandom_range(0, 15));
                        else
                            ety = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 127) :
                                  $urandom_range(0, 65535);
                        // base-128 type, most significant group first
                        grp.delete();
                        v = ety;
                        do begin
                            grp.push_front(8'(v & 'h7F));
                            v = v >> 7;
                        end while (v != 0);
                        if (huge) begin
                            while (grp.size() < 3)
                                grp.push_front(8'h00);
                            grp.push_front(8'($urandom_range(4, 127)));
                        end
                        for (int i = 0; i < grp.size(); i++)
                            frame.push_back(i == grp.size() - 1 ? grp[i] : grp[i] | 8'h80);
                        k = $urandom_range(0, 9);
                        len = (k < 7) ? $urandom_range(0, 4) :
                              (k < 9) ? $urandom_range(5, 10) : $urandom_range(0, 255);
                        frame.push_back(8'(len));
                        repeat (len) frame.push_back(8'($urandom));
                    end
                    if ($urandom_range(0, 3) == 0 || frame.size() > HDR_LEN + plen + 8)
                        while (frame.size() > HDR_LEN + plen)
                            void'(frame.pop_back());
                end
                else
                begin
                    // far past the size limit, the longer ones saturate the position counter
                    n = $urandom_range(250, 300);
                    repeat (n) frame.push_back(8'($urandom));
                end
                send_frame();
                budget += frame.size();
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        $display("tb: %0d messages of %0d bytes sent, %0d results checked, %0d register writes",
                 frames_sent, bytes_sent, results_seen, writes_done);
        $display("tb: directed cases plus %0d random phases under four idling patterns", PHASES);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
